### rtl/core/gps_coordinate_moving_average_assert.svh
// Assertion macros shared by the moving-average filter.
`ifndef GPS_COORDINATE_MOVING_AVERAGE_ASSERT_SVH
`define GPS_COORDINATE_MOVING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gcma_pkg.sv
package gcma_pkg;

    localparam int AXIS_W = 32;
    localparam int LAT_W = 31;
    localparam int FRAC_W = 25;
    localparam int FMAG_W = 24;
    localparam int REM_W = FMAG_W + 1;
    localparam int EST_W = 8;
    localparam int AVG_W = AXIS_W + 2;

    // Whole degrees are estimated as floor(mag * 429 / 2^32), at most one too low.
    localparam int RECIP_W = 9;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] DEG_RECIP = 9'd429;
    localparam logic [FMAG_W-1:0] DEG_SCALE = 24'd10000000;

    localparam int DIGIT_SCALE = 10000;
    localparam int DIGIT_LOW = 1;
    localparam int DIGIT_HIGH = 999;
    localparam logic [FMAG_W-1:0] DIGIT_MIN_MAG = FMAG_W'((DIGIT_LOW + 1) * DIGIT_SCALE);
    localparam logic [FMAG_W-1:0] DIGIT_END_MAG = FMAG_W'(DIGIT_HIGH * DIGIT_SCALE);

    localparam int NUM_STAGES = 7;
    localparam int ST_IN = 0;
    localparam int ST_EST = 1;
    localparam int ST_SCALE = 2;
    localparam int ST_FRAC = 3;
    localparam int ST_RING = 4;
    localparam int ST_QUOT = 5;
    localparam int ST_OUT = 6;

    typedef struct packed {
        logic signed [LAT_W-1:0]  latitude_in;
        logic signed [AXIS_W-1:0] longitude_in;
        logic                     hold_mode;
    } t_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0] latitude_out;
        logic signed [AXIS_W-1:0] longitude_out;
        logic                     latitude_averaged;
        logic                     longitude_averaged;
    } t_out;

    typedef struct packed {
        logic signed [FRAC_W-1:0] lat;
        logic signed [FRAC_W-1:0] lon;
    } t_frac_pair;

    typedef struct packed {
        logic st_est;
        logic st_scale;
        logic st_frac;
    } t_split_en;

    typedef struct packed {
        logic st_quot;
        logic st_out;
    } t_avg_en;

endpackage

### rtl/core/gcma_split.sv
module gcma_split (
    input  logic                                    i_clk,
    input  gcma_pkg::t_split_en                     i_en,
    input  logic signed [gcma_pkg::AXIS_W-1:0]      i_raw,
    input  logic                                    i_hold,
    output logic signed [gcma_pkg::AXIS_W-1:0]      o_raw,
    output logic signed [gcma_pkg::FRAC_W-1:0]      o_frac,
    output logic                                    o_avg_ok
);

    localparam int PROD_W = gcma_pkg::AXIS_W + gcma_pkg::RECIP_W;

    logic [gcma_pkg::AXIS_W-1:0]            w_mag;
    logic [PROD_W-1:0]                      w_prod;
    logic [gcma_pkg::AXIS_W-1:0]            w_scaled;
    logic [gcma_pkg::REM_W-1:0]             w_rem;
    logic [gcma_pkg::REM_W-1:0]             w_fix;
    logic [gcma_pkg::FMAG_W-1:0]            w_fmag;

    logic [gcma_pkg::EST_W-1:0]             r1_est;
    logic [gcma_pkg::AXIS_W-1:0]            r1_mag;
    logic                                   r1_neg;
    logic signed [gcma_pkg::AXIS_W-1:0]     r1_raw;
    logic                                   r1_hold;

    logic [gcma_pkg::AXIS_W-1:0]            r2_scaled;
    logic [gcma_pkg::AXIS_W-1:0]            r2_mag;
    logic                                   r2_neg;
    logic signed [gcma_pkg::AXIS_W-1:0]     r2_raw;
    logic                                   r2_hold;

    logic signed [gcma_pkg::FRAC_W-1:0]     r3_frac;
    logic                                   r3_ok;
    logic signed [gcma_pkg::AXIS_W-1:0]     r3_raw;

    assign w_mag = i_raw[gcma_pkg::AXIS_W-1] ? (~$unsigned(i_raw) + 1'b1) : $unsigned(i_raw);
    assign w_prod = {{gcma_pkg::RECIP_W{1'b0}}, w_mag}
                  * {{gcma_pkg::AXIS_W{1'b0}}, gcma_pkg::DEG_RECIP};

    assign w_scaled = gcma_pkg::AXIS_W'(r1_est) * gcma_pkg::AXIS_W'(gcma_pkg::DEG_SCALE);

    assign w_rem = gcma_pkg::REM_W'(r2_mag - r2_scaled);
    assign w_fix = (w_rem >= {1'b0, gcma_pkg::DEG_SCALE}) ? (w_rem - {1'b0, gcma_pkg::DEG_SCALE})
                                                         : w_rem;
    assign w_fmag = w_fix[gcma_pkg::FMAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.st_est) begin
            r1_est  <= w_prod[gcma_pkg::RECIP_SHIFT +: gcma_pkg::EST_W];
            r1_mag  <= w_mag;
            r1_neg  <= i_raw[gcma_pkg::AXIS_W-1];
            r1_raw  <= i_raw;
            r1_hold <= i_hold;
        end
        if (i_en.st_scale) begin
            r2_scaled <= w_scaled;
            r2_mag    <= r1_mag;
            r2_neg    <= r1_neg;
            r2_raw    <= r1_raw;
            r2_hold   <= r1_hold;
        end
        if (i_en.st_frac) begin
            r3_frac <= r2_neg ? -$signed({1'b0, w_fmag}) : $signed({1'b0, w_fmag});
            r3_ok   <= r2_hold && (w_fmag >= gcma_pkg::DIGIT_MIN_MAG)
                               && (w_fmag < gcma_pkg::DIGIT_END_MAG);
            r3_raw  <= r2_raw;
        end
    end

    assign o_raw    = r3_raw;
    assign o_frac   = r3_frac;
    assign o_avg_ok = r3_ok;

endmodule

### rtl/core/gcma_cell.sv
module gcma_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  gcma_pkg::t_frac_pair i_frac,
    output gcma_pkg::t_frac_pair o_frac
);

    gcma_pkg::t_frac_pair r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= '0;
        end else if (i_shift) begin
            r_frac <= i_frac;
        end
    end

    assign o_frac = r_frac;

endmodule

### rtl/core/gcma_avg.sv
module gcma_avg #(
    parameter int WINDOW = 5
) (
    input  logic                                                   i_clk,
    input  gcma_pkg::t_avg_en                                      i_en,
    input  logic signed [gcma_pkg::FRAC_W+$clog2(WINDOW)-1:0]      i_sum,
    input  logic signed [gcma_pkg::FRAC_W-1:0]                     i_frac,
    input  logic signed [gcma_pkg::AXIS_W-1:0]                     i_raw,
    input  logic                                                   i_ok,
    output logic signed [gcma_pkg::AXIS_W-1:0]                     o_value,
    output logic                                                   o_averaged
);

    localparam int W_BITS = $clog2(WINDOW);
    localparam int SUM_W = gcma_pkg::FRAC_W + W_BITS;
    localparam int MAG_W = SUM_W - 1;
    localparam int QSHIFT = MAG_W + W_BITS;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << QSHIFT) + 64'(WINDOW) - 64'd1)
                                       / 64'(WINDOW);
    localparam logic [QSHIFT-1:0] RECIP = RECIP_FULL[QSHIFT-1:0];
    localparam int AVG_W = gcma_pkg::AVG_W;
    localparam int AXIS_W = gcma_pkg::AXIS_W;

    logic [SUM_W-1:0]               w_abs;
    logic [MAG_W+QSHIFT-1:0]        w_prod;
    logic signed [AVG_W-1:0]        w_q_pos;
    logic signed [AVG_W-1:0]        w_q;
    logic signed [AVG_W-1:0]        w_avg;
    logic                           w_fits;
    logic signed [AXIS_W-1:0]       w_sat;

    logic [MAG_W-1:0]               r5_qmag;
    logic                           r5_neg;
    logic signed [gcma_pkg::FRAC_W-1:0] r5_frac;
    logic signed [AXIS_W-1:0]       r5_raw;
    logic                           r5_ok;

    logic signed [AXIS_W-1:0]       r6_value;
    logic                           r6_averaged;

    assign w_abs = i_sum[SUM_W-1] ? (~$unsigned(i_sum) + 1'b1) : $unsigned(i_sum);
    assign w_prod = {{QSHIFT{1'b0}}, w_abs[MAG_W-1:0]} * {{MAG_W{1'b0}}, RECIP};

    assign w_q_pos = $signed({{(AVG_W - MAG_W){1'b0}}, r5_qmag});
    assign w_q     = r5_neg ? -w_q_pos : w_q_pos;
    assign w_avg   = AVG_W'(r5_raw) - AVG_W'(r5_frac) + w_q;
    assign w_fits  = (&w_avg[AVG_W-1:AXIS_W-1]) || !(|w_avg[AVG_W-1:AXIS_W-1]);
    assign w_sat   = w_fits ? w_avg[AXIS_W-1:0]
                   : (w_avg[AVG_W-1] ? $signed({1'b1, {(AXIS_W-1){1'b0}}})
                                     : $signed({1'b0, {(AXIS_W-1){1'b1}}}));

    always_ff @(posedge i_clk) begin
        if (i_en.st_quot) begin
            r5_qmag <= w_prod[QSHIFT +: MAG_W];
            r5_neg  <= i_sum[SUM_W-1];
            r5_frac <= i_frac;
            r5_raw  <= i_raw;
            r5_ok   <= i_ok;
        end
        if (i_en.st_out) begin
            r6_value    <= r5_ok ? w_sat : r5_raw;
            r6_averaged <= r5_ok;
        end
    end

    assign o_value    = r6_value;
    assign o_averaged = r6_averaged;

endmodule

### rtl/core/gps_coordinate_moving_average.sv
// Moving-average filter for GPS latitude and longitude fixes.
// The input channel (i_valid, o_ready, i_data) carries one fix per item: latitude and
// longitude in 1e-7 degree and a position-hold flag. The output channel (o_valid,
// i_ready, o_data) returns exactly one item per fix, in order, with each coordinate
// either passed through or replaced by the average of the last WINDOW fractions plus
// the current whole degrees, and a flag per axis saying which.
// The datapath is a seven-register pipeline in which every stage that empties refills
// at once, so one item is taken per cycle while o_ready is high. The fraction history is
// a shift chain of WINDOW cells; the running sums change once per item in one stage,
// which sets no limit below one item a cycle.
// Reset clears the pipeline, the cells and the sums, so early averages count zeros.
// When the receiver stalls, items pile up in the free pipeline registers; o_ready drops
// only when all seven hold an item, and a waiting result stays unchanged until taken.
`include "gps_coordinate_moving_average_assert.svh"

module gps_coordinate_moving_average #(
    parameter int WINDOW = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gcma_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output gcma_pkg::t_out   o_data
);

    localparam int NST = gcma_pkg::NUM_STAGES;
    localparam int SUM_W = gcma_pkg::FRAC_W + $clog2(WINDOW);
    localparam int AXIS_W = gcma_pkg::AXIS_W;
    localparam int FRAC_W = gcma_pkg::FRAC_W;

    logic [NST-1:0]                 r_vld;
    logic [NST-1:0]                 n_vld;
    logic [NST-1:0]                 w_rdy;
    logic [NST-1:0]                 w_ld;

    gcma_pkg::t_in                  r0_data;
    logic signed [AXIS_W-1:0]       w_lat_raw;

    gcma_pkg::t_split_en            w_split_en;
    gcma_pkg::t_avg_en              w_avg_en;

    logic signed [AXIS_W-1:0]       w_lat_s3_raw;
    logic signed [AXIS_W-1:0]       w_lon_s3_raw;
    logic                           w_lat_s3_ok;
    logic                           w_lon_s3_ok;
    gcma_pkg::t_frac_pair           w_new;
    gcma_pkg::t_frac_pair           w_chain [WINDOW];

    logic signed [SUM_W-1:0]        r_sum_lat;
    logic signed [SUM_W-1:0]        r_sum_lon;
    logic signed [SUM_W-1:0]        n_sum_lat;
    logic signed [SUM_W-1:0]        n_sum_lon;

    logic signed [AXIS_W-1:0]       r4_lat_raw;
    logic signed [AXIS_W-1:0]       r4_lon_raw;
    logic signed [FRAC_W-1:0]       r4_lat_frac;
    logic signed [FRAC_W-1:0]       r4_lon_frac;
    logic                           r4_lat_ok;
    logic                           r4_lon_ok;

    logic signed [SUM_W-1:0]        w_chk_lat;
    logic signed [SUM_W-1:0]        w_chk_lon;

    // Each stage can take a new item when it is empty or its item moves on.
    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_ld[0] = i_valid && w_rdy[0];
        for (int k = 1; k < NST; k++) begin
            w_ld[k] = r_vld[k-1] && w_rdy[k];
        end
        for (int k = 0; k < NST - 1; k++) begin
            n_vld[k] = w_ld[k] || (r_vld[k] && !w_rdy[k+1]);
        end
        n_vld[NST-1] = w_ld[NST-1] || (r_vld[NST-1] && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[gcma_pkg::ST_IN]) begin
            r0_data <= i_data;
        end
    end

    assign w_lat_raw = AXIS_W'(r0_data.latitude_in);

    assign w_split_en.st_est   = w_ld[gcma_pkg::ST_EST];
    assign w_split_en.st_scale = w_ld[gcma_pkg::ST_SCALE];
    assign w_split_en.st_frac  = w_ld[gcma_pkg::ST_FRAC];

    gcma_split u_split_lat (
        .i_clk    (i_clk),
        .i_en     (w_split_en),
        .i_raw    (w_lat_raw),
        .i_hold   (r0_data.hold_mode),
        .o_raw    (w_lat_s3_raw),
        .o_frac   (w_new.lat),
        .o_avg_ok (w_lat_s3_ok)
    );

    gcma_split u_split_lon (
        .i_clk    (i_clk),
        .i_en     (w_split_en),
        .i_raw    (r0_data.longitude_in),
        .i_hold   (r0_data.hold_mode),
        .o_raw    (w_lon_s3_raw),
        .o_frac   (w_new.lon),
        .o_avg_ok (w_lon_s3_ok)
    );

    for (genvar g = 0; g < WINDOW; g++) begin : g_ring
        if (g == 0) begin : g_head
            gcma_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ld[gcma_pkg::ST_RING]),
                .i_frac  (w_new),
                .o_frac  (w_chain[g])
            );
        end else begin : g_body
            gcma_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ld[gcma_pkg::ST_RING]),
                .i_frac  (w_chain[g-1]),
                .o_frac  (w_chain[g])
            );
        end
    end

    // The oldest fraction leaves the window as the new one enters.
    assign n_sum_lat = r_sum_lat + SUM_W'(w_new.lat) - SUM_W'(w_chain[WINDOW-1].lat);
    assign n_sum_lon = r_sum_lon + SUM_W'(w_new.lon) - SUM_W'(w_chain[WINDOW-1].lon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_lat <= '0;
            r_sum_lon <= '0;
        end else if (w_ld[gcma_pkg::ST_RING]) begin
            r_sum_lat <= n_sum_lat;
            r_sum_lon <= n_sum_lon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[gcma_pkg::ST_RING]) begin
            r4_lat_raw  <= w_lat_s3_raw;
            r4_lon_raw  <= w_lon_s3_raw;
            r4_lat_frac <= w_new.lat;
            r4_lon_frac <= w_new.lon;
            r4_lat_ok   <= w_lat_s3_ok;
            r4_lon_ok   <= w_lon_s3_ok;
        end
    end

    assign w_avg_en.st_quot = w_ld[gcma_pkg::ST_QUOT];
    assign w_avg_en.st_out  = w_ld[gcma_pkg::ST_OUT];

    gcma_avg #(
        .WINDOW (WINDOW)
    ) u_avg_lat (
        .i_clk      (i_clk),
        .i_en       (w_avg_en),
        .i_sum      (r_sum_lat),
        .i_frac     (r4_lat_frac),
        .i_raw      (r4_lat_raw),
        .i_ok       (r4_lat_ok),
        .o_value    (o_data.latitude_out),
        .o_averaged (o_data.latitude_averaged)
    );

    gcma_avg #(
        .WINDOW (WINDOW)
    ) u_avg_lon (
        .i_clk      (i_clk),
        .i_en       (w_avg_en),
        .i_sum      (r_sum_lon),
        .i_frac     (r4_lon_frac),
        .i_raw      (r4_lon_raw),
        .i_ok       (r4_lon_ok),
        .o_value    (o_data.longitude_out),
        .o_averaged (o_data.longitude_averaged)
    );

    assign o_valid = r_vld[gcma_pkg::ST_OUT];
    assign o_ready = w_rdy[gcma_pkg::ST_IN];

    always_comb begin
        w_chk_lat = '0;
        w_chk_lon = '0;
        for (int k = 0; k < WINDOW; k++) begin
            w_chk_lat = w_chk_lat + SUM_W'(w_chain[k].lat);
            w_chk_lon = w_chk_lon + SUM_W'(w_chain[k].lon);
        end
    end

    `GCMA_ASSERT_NOW(a_blocked_only_when_full, !o_ready, &r_vld, "input blocked with a free stage")
    `GCMA_ASSERT_NOW(a_lat_sum_matches_ring, 1'b1, r_sum_lat == w_chk_lat, "latitude sum drifted")
    `GCMA_ASSERT_NOW(a_lon_sum_matches_ring, 1'b1, r_sum_lon == w_chk_lon, "longitude sum drifted")
    `GCMA_ASSERT_NEXT(a_output_fills, r_vld[gcma_pkg::ST_QUOT] && !o_valid, o_valid, "result lost")

endmodule
